// ===== rtl/core/qmrt_pkg.sv =====
package qmrt_pkg;

  localparam int MAG_W    = 62;
  localparam int POR_BITS = 16;
  localparam int POR_W    = POR_BITS + 1;
  localparam int MUL_LAT  = 3;
  localparam int PADDR_W  = 5;
  localparam int DATA_W   = 32;

  localparam logic [POR_W-1:0] POR_ONE         = POR_W'(1) << POR_BITS;
  localparam logic [MAG_W-1:0] MAG_CAP         = '1;
  localparam logic [POR_W-1:0] SECONDS_PER_DAY = POR_W'(86400);

  // register index, byte address is 4 * index
  typedef enum logic [2:0] {
    REG_MORT_COEFF = 3'd0,
    REG_DET_FRAC   = 3'd1,
    REG_OXY_HALF   = 3'd2,
    REG_RATIO_P    = 3'd3,
    REG_RATIO_C    = 3'd4,
    REG_RATIO_O    = 3'd5,
    REG_OPT_OUT    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic             clip;
    logic [MAG_W-1:0] mag;
  } mag_t;

  typedef struct packed {
    logic [31:0]      mortality_coeff;
    logic [POR_W-1:0] detritus_fraction;
    logic [31:0]      oxygen_half_sat;
    logic [31:0]      ratio_phosphorus;
    logic [31:0]      ratio_carbon;
    logic [31:0]      ratio_oxygen;
    logic [2:0]       optional_outputs;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        zoo_nitrogen;
    logic signed [31:0] oxygen_level;
    logic [POR_W-1:0]   porosity;
    logic [31:0]        temp_factor;
    logic [31:0]        layer_thickness;
  } in_t;

  typedef struct packed {
    logic signed [31:0] d_zoo;
    logic signed [31:0] d_ammonium;
    logic signed [31:0] d_phosphate;
    logic signed [31:0] d_inorganic_carbon;
    logic signed [31:0] d_detritus;
    logic signed [31:0] d_oxygen;
    logic signed [31:0] d_demand;
    logic signed [31:0] ammonium_daily;
    logic signed [31:0] oxygen_daily;
    logic               saturated;
  } out_t;

endpackage

// ===== rtl/core/qmrt_dly.sv =====
module qmrt_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [N];

  always_ff @(posedge clk) begin
    sr_r[0] <= d;
    for (int i = 1; i < N; i++) begin
      sr_r[i] <= sr_r[i-1];
    end
  end

  assign q = sr_r[N-1];

endmodule

// ===== rtl/core/qmrt_mul.sv =====
module qmrt_mul import qmrt_pkg::*; #(
  parameter int SH = 16
) (
  input  logic             clk,
  input  logic [MAG_W-1:0] a,
  input  logic [MAG_W-1:0] b,
  input  logic             clip_in,
  output logic [MAG_W-1:0] p,
  output logic             clip
);

  localparam int SHR = (SH > 0) ? SH - 1 : 0;
  localparam logic [127:0] RND = (SH > 0) ? (128'(1) << SHR) : 128'(0);

  logic [63:0]  a64, b64;
  logic [63:0]  pp00_r, pp01_r, pp10_r, pp11_r;
  logic         clip1_r, clip2_r, clip_r;
  logic [127:0] prod_r, sft;
  logic [MAG_W-1:0] p_r;

  assign a64 = 64'(a);
  assign b64 = 64'(b);

  // partial products of 32-bit halves
  always_ff @(posedge clk) begin
    pp00_r  <= a64[31:0]  * b64[31:0];
    pp01_r  <= a64[31:0]  * b64[63:32];
    pp10_r  <= a64[63:32] * b64[31:0];
    pp11_r  <= a64[63:32] * b64[63:32];
    clip1_r <= clip_in;
  end

  always_ff @(posedge clk) begin
    prod_r  <= 128'(pp00_r) + (128'(pp01_r) << 32) + (128'(pp10_r) << 32)
             + (128'(pp11_r) << 64);
    clip2_r <= clip1_r;
  end

  assign sft = (prod_r + RND) >> SH;

  always_ff @(posedge clk) begin
    if (sft > 128'(MAG_CAP)) begin
      p_r    <= MAG_CAP;
      clip_r <= 1'b1;
    end else begin
      p_r    <= sft[MAG_W-1:0];
      clip_r <= clip2_r;
    end
  end

  assign p    = p_r;
  assign clip = clip_r;

endmodule

// ===== rtl/core/qmrt_div.sv =====
module qmrt_div #(
  parameter int WN = 78,
  parameter int WD = 17,
  parameter int WQ = 78,
  parameter int WT = 1
) (
  input  logic          clk,
  input  logic [WN-1:0] dvd,
  input  logic [WD-1:0] dvs,
  input  logic [WT-1:0] tag_in,
  output logic [WQ-1:0] quo,
  output logic [WT-1:0] tag_out
);

  localparam int WX = WD + WQ;

  logic [WX-1:0] rem_r [WQ];
  logic [WD-1:0] dvs_r [WQ];
  logic [WQ-1:0] quo_r [WQ];
  logic [WT-1:0] tag_r [WQ];

  // restoring division, one quotient bit per stage, msb first
  for (genvar k = 0; k < WQ; k++) begin : g_stage
    localparam int BIT = WQ - 1 - k;
    logic [WX-1:0] rem_in, dsh, rem_nxt;
    logic [WD-1:0] dvs_in;
    logic [WQ-1:0] quo_in, quo_nxt;
    logic [WT-1:0] tag_s;

    if (k == 0) begin : g_first
      assign rem_in = WX'(dvd);
      assign dvs_in = dvs;
      assign quo_in = '0;
      assign tag_s  = tag_in;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign dvs_in = dvs_r[k-1];
      assign quo_in = quo_r[k-1];
      assign tag_s  = tag_r[k-1];
    end

    always_comb begin
      dsh     = WX'(dvs_in) << BIT;
      quo_nxt = quo_in;
      rem_nxt = rem_in;
      if (rem_in >= dsh) begin
        rem_nxt      = rem_in - dsh;
        quo_nxt[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      dvs_r[k] <= dvs_in;
      quo_r[k] <= quo_nxt;
      tag_r[k] <= tag_s;
    end
  end

  assign quo     = quo_r[WQ-1];
  assign tag_out = tag_r[WQ-1];

endmodule

// ===== rtl/core/qmrt_regs.sv =====
module qmrt_regs import qmrt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t       cfg_r, cfg_nxt;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        REG_MORT_COEFF: cfg_nxt.mortality_coeff   = pwdata;
        REG_DET_FRAC:   cfg_nxt.detritus_fraction = pwdata[POR_W-1:0];
        REG_OXY_HALF:   cfg_nxt.oxygen_half_sat   = pwdata;
        REG_RATIO_P:    cfg_nxt.ratio_phosphorus  = pwdata;
        REG_RATIO_C:    cfg_nxt.ratio_carbon      = pwdata;
        REG_RATIO_O:    cfg_nxt.ratio_oxygen      = pwdata;
        REG_OPT_OUT:    cfg_nxt.optional_outputs  = pwdata[2:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_MORT_COEFF: prdata = cfg_r.mortality_coeff;
      REG_DET_FRAC:   prdata = DATA_W'(cfg_r.detritus_fraction);
      REG_OXY_HALF:   prdata = cfg_r.oxygen_half_sat;
      REG_RATIO_P:    prdata = cfg_r.ratio_phosphorus;
      REG_RATIO_C:    prdata = cfg_r.ratio_carbon;
      REG_RATIO_O:    prdata = cfg_r.ratio_oxygen;
      REG_OPT_OUT:    prdata = DATA_W'(cfg_r.optional_outputs);
      default:        prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/quadratic_mortality_rate_terms.sv =====
// Streams one sediment cell per clock: busy never rises, so start may be held
// high every cycle. Each cell produces one result, strobed by out_valid for a
// single cycle. The latency is set by the two 78-stage porosity dividers in
// series (ammonium, then oxygen) and six 3-stage multiplies; the sigmoid
// divider runs beside them. Results cannot be held off by the receiver and
// come out in order.
module quadratic_mortality_rate_terms import qmrt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_t                in_data,
  output logic               out_valid,
  output out_t               out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int LM     = MUL_LAT;
  localparam int DPN    = MAG_W + POR_BITS;
  localparam int LDP    = 1 + DPN;
  localparam int WSQ    = FRAC_BITS + 1;
  localparam int WSN    = MAG_W + FRAC_BITS + 1;
  localparam int LDS    = 2 + WSQ;
  localparam int T_MORT = 2 * LM;
  localparam int T_M1   = 3 * LM;
  localparam int T_NH4  = T_M1 + LDP;
  localparam int T_PROD = T_NH4 + LM;
  localparam int T_TS   = T_PROD + LM;
  localparam int T_OXY  = T_TS + LDP;
  localparam int T_FIN  = T_OXY + LM;

  localparam logic [WSQ-1:0] ONE_S = WSQ'(1) << FRAC_BITS;

  typedef struct packed {
    logic        clip;
    logic [31:0] val;
  } s32_t;

  function automatic mag_t sat_por(input logic [DPN-1:0] q, input logic cl);
    mag_t r;
    if (q > DPN'(MAG_CAP)) begin
      r.mag  = MAG_CAP;
      r.clip = 1'b1;
    end else begin
      r.mag  = q[MAG_W-1:0];
      r.clip = cl;
    end
    return r;
  endfunction

  function automatic s32_t to_s32(input logic [MAG_W-1:0] mag, input logic neg);
    s32_t r;
    r.clip = 1'b0;
    if (neg) begin
      if (mag > MAG_W'(33'h1_0000_0000 >> 1)) begin
        r.clip = 1'b1;
        r.val  = 32'h8000_0000;
      end else begin
        r.val = 32'(0) - mag[31:0];
      end
    end else begin
      if (mag > MAG_W'(32'h7FFF_FFFF)) begin
        r.clip = 1'b1;
        r.val  = 32'h7FFF_FFFF;
      end else begin
        r.val = mag[31:0];
      end
    end
    return r;
  endfunction

  function automatic logic [DPN-1:0] por_dvd(input logic [MAG_W-1:0] m,
                                             input logic [POR_W-1:0] por);
    return {m, POR_BITS'(0)} + DPN'(por[POR_W-1:1]);
  endfunction

  cfg_t cfg;

  qmrt_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg
  );

  logic             accept;
  logic [T_FIN:0]   vld_r;
  logic             out_valid_r;
  in_t              in_r;
  out_t             out_r, out_nxt;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[T_FIN-1:0], accept};
      out_valid_r <= vld_r[T_FIN];
    end
  end

  always_ff @(posedge clk) begin
    in_r  <= in_data;
    out_r <= out_nxt;
  end

  // input conditioning
  logic [MAG_W-1:0] ox0;
  logic [POR_W-1:0] por0, fdm;

  assign ox0  = in_r.oxygen_level[31] ? '0 : MAG_W'(in_r.oxygen_level[30:0]);
  assign por0 = (in_r.porosity == '0) ? POR_W'(1)
              : (in_r.porosity > POR_ONE) ? POR_ONE : in_r.porosity;
  assign fdm  = (cfg.detritus_fraction > POR_ONE) ? POR_ONE : cfg.detritus_fraction;

  logic [MAG_W-1:0] mq, zz, o2, k2, mort, m1, det;
  logic             mq_c, zz_c, o2_c, k2_c, mort_c, m1_c, det_c;

  qmrt_mul #(.SH(FRAC_BITS)) u_mq (.clk, .a(MAG_W'(cfg.mortality_coeff)),
    .b(MAG_W'(in_r.temp_factor)), .clip_in(1'b0), .p(mq), .clip(mq_c));
  qmrt_mul #(.SH(FRAC_BITS)) u_zz (.clk, .a(MAG_W'(in_r.zoo_nitrogen)),
    .b(MAG_W'(in_r.zoo_nitrogen)), .clip_in(1'b0), .p(zz), .clip(zz_c));
  qmrt_mul #(.SH(FRAC_BITS)) u_o2 (.clk, .a(ox0), .b(ox0), .clip_in(1'b0),
    .p(o2), .clip(o2_c));
  qmrt_mul #(.SH(FRAC_BITS)) u_k2 (.clk, .a(MAG_W'(cfg.oxygen_half_sat)),
    .b(MAG_W'(cfg.oxygen_half_sat)), .clip_in(1'b0), .p(k2), .clip(k2_c));

  qmrt_mul #(.SH(FRAC_BITS)) u_mort (.clk, .a(zz), .b(mq), .clip_in(zz_c | mq_c),
    .p(mort), .clip(mort_c));

  qmrt_mul #(.SH(POR_BITS)) u_m1 (.clk, .a(mort), .b(MAG_W'(POR_ONE - fdm)),
    .clip_in(mort_c), .p(m1), .clip(m1_c));
  qmrt_mul #(.SH(POR_BITS)) u_det (.clk, .a(mort), .b(MAG_W'(fdm)),
    .clip_in(mort_c), .p(det), .clip(det_c));

  // porosity follows the data to both divider fronts
  logic [POR_W-1:0] por_a, por_b;

  qmrt_dly #(.W(POR_W), .N(T_M1)) u_dpor_a (.clk, .d(por0), .q(por_a));
  qmrt_dly #(.W(POR_W), .N(T_TS - T_M1)) u_dpor_b (.clk, .d(por_a), .q(por_b));

  // ammonium release: m1 / porosity
  logic [DPN-1:0]   nd_r, q_nh4;
  logic [POR_W-1:0] nd_por_r;
  logic             nd_c_r, q_nh4_c;
  mag_t             nh4;

  always_ff @(posedge clk) begin
    nd_r     <= por_dvd(m1, por_a);
    nd_por_r <= por_a;
    nd_c_r   <= m1_c;
  end

  qmrt_div #(.WN(DPN), .WD(POR_W), .WQ(DPN), .WT(1)) u_div_nh4 (.clk, .dvd(nd_r),
    .dvs(nd_por_r), .tag_in(nd_c_r), .quo(q_nh4), .tag_out(q_nh4_c));

  assign nh4 = sat_por(q_nh4, q_nh4_c);

  // aerobic sigmoid o2 / (o2 + k2)
  logic [MAG_W:0]           den_r, sden_r;
  logic [MAG_W+FRAC_BITS-1:0] o2s_r;
  logic                     sc1_r;
  logic [WSN-1:0]           sdvd_r;
  logic [1:0]               stag_r, stag_o;
  logic [WSQ-1:0]           squo, sig, sig_d;
  logic                     sig_c, sigd_c;

  always_ff @(posedge clk) begin
    den_r  <= (MAG_W+1)'(o2) + (MAG_W+1)'(k2);
    o2s_r  <= {o2, FRAC_BITS'(0)};
    sc1_r  <= o2_c | k2_c;
    sdvd_r <= WSN'(o2s_r) + WSN'(den_r[MAG_W:1]);
    sden_r <= den_r;
    stag_r <= {den_r == '0, sc1_r};
  end

  qmrt_div #(.WN(WSN), .WD(MAG_W+1), .WQ(WSQ), .WT(2)) u_div_sig (.clk,
    .dvd(sdvd_r), .dvs(sden_r), .tag_in(stag_r), .quo(squo), .tag_out(stag_o));

  // zero denominator gives zero
  assign sig   = stag_o[1] ? '0 : (squo > ONE_S) ? ONE_S : squo;
  assign sig_c = stag_o[0];

  qmrt_dly #(.W(WSQ+1), .N(T_PROD - LM - LDS)) u_dsig (.clk, .d({sig_c, sig}),
    .q({sigd_c, sig_d}));

  logic [31:0] dz_d;

  qmrt_dly #(.W(32), .N(T_PROD)) u_ddz (.clk, .d(in_r.layer_thickness), .q(dz_d));

  // products of released nitrogen
  logic [MAG_W-1:0] t_o, p_ph, p_c, a1, a2, a3, ts, tn, oxd;
  logic             t_c, ph_c, c_c, a1_c, a2_c, a3_c, ts_c, tn_c, oxd_c;

  qmrt_mul #(.SH(FRAC_BITS)) u_t (.clk, .a(nh4.mag), .b(MAG_W'(cfg.ratio_oxygen)),
    .clip_in(nh4.clip), .p(t_o), .clip(t_c));
  qmrt_mul #(.SH(FRAC_BITS)) u_ph (.clk, .a(nh4.mag),
    .b(MAG_W'(cfg.ratio_phosphorus)), .clip_in(nh4.clip), .p(p_ph), .clip(ph_c));
  qmrt_mul #(.SH(FRAC_BITS)) u_c (.clk, .a(nh4.mag), .b(MAG_W'(cfg.ratio_carbon)),
    .clip_in(nh4.clip), .p(p_c), .clip(c_c));
  qmrt_mul #(.SH(0)) u_a1 (.clk, .a(nh4.mag), .b(MAG_W'(SECONDS_PER_DAY)),
    .clip_in(nh4.clip), .p(a1), .clip(a1_c));

  qmrt_mul #(.SH(FRAC_BITS)) u_ts (.clk, .a(t_o), .b(MAG_W'(sig_d)),
    .clip_in(t_c | sigd_c), .p(ts), .clip(ts_c));
  qmrt_mul #(.SH(FRAC_BITS)) u_tn (.clk, .a(t_o), .b(MAG_W'(ONE_S - sig_d)),
    .clip_in(t_c | sigd_c), .p(tn), .clip(tn_c));
  qmrt_mul #(.SH(FRAC_BITS)) u_a2 (.clk, .a(a1), .b(MAG_W'(dz_d)),
    .clip_in(a1_c), .p(a2), .clip(a2_c));

  qmrt_mul #(.SH(POR_BITS)) u_a3 (.clk, .a(a2), .b(MAG_W'(por_b)),
    .clip_in(a2_c), .p(a3), .clip(a3_c));

  // oxygen use and anaerobic demand, both divided by porosity
  logic [DPN-1:0]   od_r, dd_r, q_oxy, q_dem;
  logic [POR_W-1:0] od_por_r;
  logic             od_c_r, dd_c_r, q_oxy_c, q_dem_c;
  mag_t             oxy, dem;

  always_ff @(posedge clk) begin
    od_r     <= por_dvd(ts, por_b);
    dd_r     <= por_dvd(tn, por_b);
    od_por_r <= por_b;
    od_c_r   <= ts_c;
    dd_c_r   <= tn_c;
  end

  qmrt_div #(.WN(DPN), .WD(POR_W), .WQ(DPN), .WT(1)) u_div_oxy (.clk, .dvd(od_r),
    .dvs(od_por_r), .tag_in(od_c_r), .quo(q_oxy), .tag_out(q_oxy_c));
  qmrt_div #(.WN(DPN), .WD(POR_W), .WQ(DPN), .WT(1)) u_div_dem (.clk, .dvd(dd_r),
    .dvs(od_por_r), .tag_in(dd_c_r), .quo(q_dem), .tag_out(q_dem_c));

  assign oxy = sat_por(q_oxy, q_oxy_c);
  assign dem = sat_por(q_dem, q_dem_c);

  qmrt_mul #(.SH(0)) u_oxd (.clk, .a(oxy.mag), .b(MAG_W'(SECONDS_PER_DAY)),
    .clip_in(oxy.clip), .p(oxd), .clip(oxd_c));

  // line everything up for the output stage
  mag_t mort_f, det_f, nh4_f, ph_f, c_f, a3_f, oxy_f, dem_f;

  qmrt_dly #(.W(MAG_W+1), .N(T_FIN - T_MORT)) u_dmort (.clk, .d({mort_c, mort}),
    .q(mort_f));
  qmrt_dly #(.W(MAG_W+1), .N(T_FIN - T_M1)) u_ddet (.clk, .d({det_c, det}),
    .q(det_f));
  qmrt_dly #(.W(MAG_W+1), .N(T_FIN - T_NH4)) u_dnh4 (.clk, .d(nh4), .q(nh4_f));
  qmrt_dly #(.W(MAG_W+1), .N(T_FIN - T_PROD)) u_dph (.clk, .d({ph_c, p_ph}),
    .q(ph_f));
  qmrt_dly #(.W(MAG_W+1), .N(T_FIN - T_PROD)) u_dc (.clk, .d({c_c, p_c}), .q(c_f));
  qmrt_dly #(.W(MAG_W+1), .N(T_FIN - T_TS - LM)) u_da3 (.clk, .d({a3_c, a3}),
    .q(a3_f));
  qmrt_dly #(.W(MAG_W+1), .N(T_FIN - T_OXY)) u_doxy (.clk, .d(oxy), .q(oxy_f));
  qmrt_dly #(.W(MAG_W+1), .N(T_FIN - T_OXY)) u_ddem (.clk, .d(dem), .q(dem_f));

  s32_t s_zoo, s_nh4, s_ph, s_c, s_det, s_oxy, s_dem, s_ad, s_od;
  logic en_dem, en_ad, en_od, sat_req, sat_opt;

  assign en_dem = cfg.optional_outputs[0];
  assign en_ad  = cfg.optional_outputs[1];
  assign en_od  = cfg.optional_outputs[2];

  always_comb begin
    s_zoo = to_s32(mort_f.mag, 1'b1);
    s_nh4 = to_s32(nh4_f.mag, 1'b0);
    s_ph  = to_s32(ph_f.mag, 1'b0);
    s_c   = to_s32(c_f.mag, 1'b0);
    s_det = to_s32(det_f.mag, 1'b0);
    s_oxy = to_s32(oxy_f.mag, 1'b1);
    s_dem = to_s32(dem_f.mag, 1'b0);
    s_ad  = to_s32(a3_f.mag, 1'b0);
    s_od  = to_s32(oxd, 1'b1);

    // every clip of the mandatory chain shows up in one of these
    sat_req = mort_f.clip | nh4_f.clip | ph_f.clip | c_f.clip | det_f.clip
            | oxy_f.clip | s_zoo.clip | s_nh4.clip | s_ph.clip | s_c.clip
            | s_det.clip | s_oxy.clip;
    sat_opt = (en_dem & (dem_f.clip | s_dem.clip))
            | (en_ad & (a3_f.clip | s_ad.clip))
            | (en_od & (oxd_c | s_od.clip));

    out_nxt.d_zoo              = s_zoo.val;
    out_nxt.d_ammonium         = s_nh4.val;
    out_nxt.d_phosphate        = s_ph.val;
    out_nxt.d_inorganic_carbon = s_c.val;
    out_nxt.d_detritus         = s_det.val;
    out_nxt.d_oxygen           = s_oxy.val;
    out_nxt.d_demand           = en_dem ? s_dem.val : '0;
    out_nxt.ammonium_daily     = en_ad ? s_ad.val : '0;
    out_nxt.oxygen_daily       = en_od ? s_od.val : '0;
    out_nxt.saturated          = sat_req | sat_opt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
